// ----- design/size_class_slab_allocator_macros.svh -----
// Assertion macros used by the allocator datapath.
`ifndef SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH
`define SIZE_CLASS_SLAB_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define SCSA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scsa assertion failed");
`define SCSA_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("scsa forbidden condition");
`else
`define SCSA_ASSERT(lbl, clk, rst_n, prop)
`define SCSA_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- design/scsa_pkg.sv -----
package scsa_pkg;

    localparam int NUM_CLASSES    = 10;
    localparam int MIN_SHIFT      = 6;
    localparam int MIN_UNIT_BYTES = 1 << MIN_SHIFT;
    localparam int MAX_PAGES      = 8;
    localparam int UNITS_MAX      = 8192;
    localparam int SLOT_W         = 3;
    localparam int PTR_W          = 4;
    localparam int CLS_W          = 4;
    localparam int UNIT_W         = 13;
    localparam int TOP_W          = 14;
    localparam int CNT_W          = 13;
    localparam int UB_W           = 17;
    localparam int REQ_W          = 32;
    localparam int OFF_W          = 19;
    localparam int BYTES_W        = 16;
    localparam int LINK_AW        = SLOT_W + UNIT_W;
    localparam int LINK_DEPTH     = 1 << LINK_AW;
    localparam int MAX_UNIT_BYTES = MIN_UNIT_BYTES << (NUM_CLASSES - 1);

    localparam logic [PTR_W-1:0] NO_SLOT = '1;
    localparam logic [TOP_W-1:0] NO_UNIT = '1;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2,
        CMD_NOP     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_PAGE   = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_GRANT,
        RES_KEEP,
        RES_MOVED
    } res_kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DISPATCH,
        S_WALK,
        S_OPEN_PAGE,
        S_POP,
        S_POP_WAIT,
        S_PUSH,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic      load;
        logic      decode;
        logic      walk_start;
        logic      walk_step;
        logic      open_page;
        logic      pop;
        logic      pop_done;
        logic      push;
        logic      finish;
        status_t   fin_status;
        res_kind_t fin_kind;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic too_large;
        logic chk_ok;
        logic keep;
        logic walk_live;
        logic walk_hit;
        logic pool_full;
        logic top_null;
        logic out_busy;
    } dp_stat_t;

    function automatic logic [UB_W-1:0] unit_bytes(input logic [CLS_W-1:0] c);
        return UB_W'(MIN_UNIT_BYTES) << c;
    endfunction

    function automatic logic [UNIT_W-1:0] units_of(input logic [CLS_W-1:0] c);
        logic [UNIT_W:0] t;
        t = (UNIT_W + 1)'(UNITS_MAX) >> c;
        return UNIT_W'(t - 1'b1);
    endfunction

    function automatic logic [CLS_W-1:0] class_of(input logic [REQ_W-1:0] req);
        logic [CLS_W-1:0] c;
        c = CLS_W'(NUM_CLASSES - 1);
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (req <= (REQ_W'(MIN_UNIT_BYTES) << i)) begin
                c = CLS_W'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [OFF_W-1:0] offset_of(input logic [UNIT_W-1:0] u,
                                                   input logic [CLS_W-1:0] c);
        logic [31:0] t;
        t = 32'(u) + 32'd1;
        t = t << (MIN_SHIFT + 32'(c));
        return t[OFF_W-1:0];
    endfunction

endpackage

// ----- design/scsa_ctrl.sv -----
module scsa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  scsa_pkg::dp_stat_t stat,
    output scsa_pkg::ctl_cmd_t cmd
);
    import scsa_pkg::*;

    state_t    state_reg, state_next;
    status_t   res_st_reg, res_st_next;
    res_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            res_st_reg <= ST_IGNORED;
            kind_reg   <= RES_ZERO;
        end
        else
        begin
            state_reg  <= state_next;
            res_st_reg <= res_st_next;
            kind_reg   <= kind_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        res_st_next    = res_st_reg;
        kind_next      = kind_reg;
        cmd            = '0;
        cmd.fin_status = res_st_reg;
        cmd.fin_kind   = kind_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                res_st_next = ST_IGNORED;
                kind_next   = RES_ZERO;
                state_next  = S_FINISH;
                case (stat.op)
                    CMD_ALLOC:
                    begin
                        if (stat.too_large)
                        begin
                            res_st_next = ST_TOO_LARGE;
                        end
                        else
                        begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    CMD_FREE:
                    begin
                        if (stat.chk_ok)
                        begin
                            res_st_next = ST_OK;
                            state_next  = S_PUSH;
                        end
                    end
                    CMD_REALLOC:
                    begin
                        if (stat.chk_ok)
                        begin
                            if (stat.keep)
                            begin
                                res_st_next = ST_OK;
                                kind_next   = RES_KEEP;
                            end
                            else if (stat.too_large)
                            begin
                                res_st_next = ST_TOO_LARGE;
                            end
                            else
                            begin
                                cmd.walk_start = 1'b1;
                                state_next     = S_WALK;
                            end
                        end
                    end
                    default:
                    begin
                        res_st_next = ST_IGNORED;
                    end
                endcase
            end
            S_WALK:
            begin
                if (stat.walk_live)
                begin
                    if (stat.walk_hit)
                    begin
                        state_next = S_POP;
                    end
                    else
                    begin
                        cmd.walk_step = 1'b1;
                    end
                end
                else if (stat.pool_full)
                begin
                    res_st_next = ST_NO_PAGE;
                    kind_next   = RES_ZERO;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_OPEN_PAGE;
                end
            end
            S_OPEN_PAGE:
            begin
                cmd.open_page = 1'b1;
                state_next    = S_POP;
            end
            S_POP, S_POP_WAIT:
            begin
                if (state_reg == S_POP)
                begin
                    cmd.pop = 1'b1;
                end
                else
                begin
                    cmd.pop_done = 1'b1;
                end
                if (state_reg == S_POP && !stat.top_null)
                begin
                    state_next = S_POP_WAIT;
                end
                else
                begin
                    res_st_next = ST_OK;
                    if (stat.op == CMD_REALLOC)
                    begin
                        kind_next  = RES_MOVED;
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        kind_next  = RES_GRANT;
                        state_next = S_FINISH;
                    end
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/scsa_datapath.sv -----
`include "size_class_slab_allocator_macros.svh"
module scsa_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  scsa_pkg::ctl_cmd_t           cmd,
    output scsa_pkg::dp_stat_t           stat,
    input  logic [1:0]                   in_cmd,
    input  logic [scsa_pkg::REQ_W-1:0]   in_req,
    input  logic [scsa_pkg::SLOT_W-1:0]  in_page,
    input  logic [scsa_pkg::OFF_W-1:0]   in_offset,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic [1:0]                   status,
    output logic [scsa_pkg::SLOT_W-1:0]  out_page,
    output logic [scsa_pkg::OFF_W-1:0]   out_offset,
    output logic [scsa_pkg::BYTES_W-1:0] granted_bytes,
    output logic                         moved,
    output logic [scsa_pkg::BYTES_W-1:0] copy_bytes
);
    import scsa_pkg::*;

    op_t               op_reg;
    logic [REQ_W-1:0]  req_reg;
    logic [SLOT_W-1:0] pg_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [CLS_W-1:0]  acls_reg;
    logic [CLS_W-1:0]  ucls_reg;
    logic [UNIT_W-1:0] uidx_reg;
    logic              big_reg;
    logic              chk_reg;
    logic              keep_reg;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  steps_reg;
    logic [SLOT_W-1:0] gpg_reg;
    logic [UNIT_W-1:0] gu_reg;

    logic              in_use_reg [MAX_PAGES];
    logic [CLS_W-1:0]  scls_reg   [MAX_PAGES];
    logic [PTR_W-1:0]  nxt_reg    [MAX_PAGES];
    logic [PTR_W-1:0]  first_reg  [NUM_CLASSES];
    logic [PTR_W-1:0]  last_reg   [NUM_CLASSES];
    logic [TOP_W-1:0]  top_reg    [MAX_PAGES];
    logic [CNT_W-1:0]  cnt_reg    [MAX_PAGES];
    logic [TOP_W-1:0]  fresh_reg  [MAX_PAGES];
    logic [PTR_W-1:0]  taken_reg;

    logic [TOP_W-1:0]  link_mem [LINK_DEPTH];
    logic [TOP_W-1:0]  link_rdata_reg;

    logic                out_valid_reg;
    status_t             status_reg;
    logic [SLOT_W-1:0]   opg_reg;
    logic [OFF_W-1:0]    ooff_reg;
    logic [BYTES_W-1:0]  gran_reg;
    logic                moved_reg;
    logic [BYTES_W-1:0]  copy_reg;

    logic [SLOT_W-1:0] idx;
    logic [SLOT_W-1:0] new_s;
    logic [CLS_W-1:0]  pcls;
    logic [UB_W-1:0]   pub;
    logic [OFF_W-1:0]  pub19;
    logic [OFF_W-1:0]  q;
    logic [UNIT_W-1:0] pu;
    logic              chk_ok;
    logic              keep;
    logic [CLS_W-1:0]  min_cls;

    assign idx   = ptr_reg[SLOT_W-1:0];
    assign new_s = taken_reg[SLOT_W-1:0];
    assign pcls  = scls_reg[idx];
    assign pub   = unit_bytes(pcls);
    assign pub19 = OFF_W'(pub);
    assign q     = off_reg >> (MIN_SHIFT + 32'(pcls));
    assign pu    = UNIT_W'(q - 1'b1);
    assign chk_ok = in_use_reg[idx] && (off_reg >= pub19)
                    && ((off_reg & (pub19 - 1'b1)) == '0)
                    && ({1'b0, pu} < fresh_reg[idx])
                    && (cnt_reg[idx] < units_of(pcls));
    assign keep  = (REQ_W'(pub) >= req_reg)
                   && (((pub >> 2) < UB_W'(MIN_UNIT_BYTES)) || (REQ_W'(pub >> 2) < req_reg));
    assign min_cls = (acls_reg < ucls_reg) ? acls_reg : ucls_reg;

    always_comb
    begin
        stat.op        = op_reg;
        stat.too_large = big_reg;
        stat.chk_ok    = chk_reg;
        stat.keep      = keep_reg;
        stat.walk_live = (ptr_reg < PTR_W'(MAX_PAGES)) && (steps_reg < PTR_W'(MAX_PAGES));
        stat.walk_hit  = (cnt_reg[idx] != '0)
                         && ((top_reg[idx] != NO_UNIT)
                             || (fresh_reg[idx] < TOP_W'(units_of(pcls))));
        stat.pool_full = taken_reg >= PTR_W'(MAX_PAGES);
        stat.top_null  = top_reg[idx] == NO_UNIT;
        stat.out_busy  = out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(in_cmd);
            req_reg <= in_req;
            pg_reg  <= in_page;
            off_reg <= in_offset;
            ptr_reg <= {1'b0, in_page};
        end
        if (cmd.decode)
        begin
            acls_reg <= class_of(req_reg);
            big_reg  <= req_reg > REQ_W'(MAX_UNIT_BYTES);
            chk_reg  <= chk_ok;
            keep_reg <= keep;
            ucls_reg <= pcls;
            uidx_reg <= pu;
        end
        if (cmd.walk_start)
        begin
            ptr_reg   <= first_reg[acls_reg];
            steps_reg <= '0;
        end
        if (cmd.walk_step)
        begin
            ptr_reg   <= nxt_reg[idx];
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.open_page)
        begin
            ptr_reg <= {1'b0, new_s};
        end
        if (cmd.pop)
        begin
            gpg_reg <= idx;
            if (top_reg[idx] == NO_UNIT)
            begin
                gu_reg  <= fresh_reg[idx][UNIT_W-1:0];
                ptr_reg <= {1'b0, pg_reg};
            end
            else
            begin
                gu_reg <= top_reg[idx][UNIT_W-1:0];
            end
        end
        if (cmd.pop_done)
        begin
            ptr_reg <= {1'b0, pg_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PAGES; i++)
            begin
                in_use_reg[i] <= 1'b0;
                scls_reg[i]   <= '0;
                nxt_reg[i]    <= NO_SLOT;
                top_reg[i]    <= NO_UNIT;
                cnt_reg[i]    <= '0;
                fresh_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                first_reg[i] <= NO_SLOT;
                last_reg[i]  <= NO_SLOT;
            end
            taken_reg <= '0;
        end
        else
        begin
            if (cmd.open_page)
            begin
                in_use_reg[new_s] <= 1'b1;
                scls_reg[new_s]   <= acls_reg;
                nxt_reg[new_s]    <= NO_SLOT;
                top_reg[new_s]    <= NO_UNIT;
                cnt_reg[new_s]    <= units_of(acls_reg);
                fresh_reg[new_s]  <= '0;
                if (last_reg[acls_reg] >= PTR_W'(MAX_PAGES))
                begin
                    first_reg[acls_reg] <= {1'b0, new_s};
                end
                else
                begin
                    nxt_reg[last_reg[acls_reg][SLOT_W-1:0]] <= {1'b0, new_s};
                end
                last_reg[acls_reg] <= {1'b0, new_s};
                taken_reg          <= taken_reg + 1'b1;
            end
            if (cmd.pop && top_reg[idx] == NO_UNIT)
            begin
                fresh_reg[idx] <= fresh_reg[idx] + 1'b1;
                cnt_reg[idx]   <= cnt_reg[idx] - 1'b1;
            end
            if (cmd.pop_done)
            begin
                top_reg[idx] <= link_rdata_reg;
                cnt_reg[idx] <= cnt_reg[idx] - 1'b1;
            end
            if (cmd.push)
            begin
                top_reg[idx] <= TOP_W'(uidx_reg);
                cnt_reg[idx] <= cnt_reg[idx] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            link_mem[{idx, uidx_reg}] <= top_reg[idx];
        end
        if (cmd.pop)
        begin
            link_rdata_reg <= link_mem[{idx, top_reg[idx][UNIT_W-1:0]}];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            opg_reg    <= '0;
            ooff_reg   <= '0;
            gran_reg   <= '0;
            moved_reg  <= 1'b0;
            copy_reg   <= '0;
            case (cmd.fin_kind)
                RES_GRANT, RES_MOVED:
                begin
                    opg_reg  <= gpg_reg;
                    ooff_reg <= offset_of(gu_reg, acls_reg);
                    gran_reg <= BYTES_W'(unit_bytes(acls_reg));
                    if (cmd.fin_kind == RES_MOVED)
                    begin
                        moved_reg <= 1'b1;
                        copy_reg  <= BYTES_W'(unit_bytes(min_cls));
                    end
                end
                RES_KEEP:
                begin
                    opg_reg  <= pg_reg;
                    ooff_reg <= off_reg;
                    gran_reg <= BYTES_W'(unit_bytes(ucls_reg));
                end
                default:
                begin
                    opg_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_page      = opg_reg;
    assign out_offset    = ooff_reg;
    assign granted_bytes = gran_reg;
    assign moved         = moved_reg;
    assign copy_bytes    = copy_reg;

    `SCSA_NEVER(a_finish_busy, clk, rst_n, cmd.finish && out_valid_reg)
    `SCSA_NEVER(a_pop_null, clk, rst_n, cmd.pop && (ptr_reg >= PTR_W'(MAX_PAGES)))
    `SCSA_NEVER(a_push_full, clk, rst_n, cmd.push && (cnt_reg[idx] >= units_of(pcls)))
    `SCSA_ASSERT(a_push_top, clk, rst_n, cmd.push |=> (top_reg[$past(idx)] == TOP_W'($past(uidx_reg))))

endmodule

// ----- design/size_class_slab_allocator.sv -----
// Slab allocator with ten power-of-two size classes (64 B to 32 KiB) over eight
// 512 KiB page slots. One command item in, one result item out. An allocate passes
// through decode and dispatch, then walks the class chain one page per step (up to
// eight pages), opens a fresh page when no page on the chain has a free unit and
// the pool is not full, and pops a unit, with a wait state when the unit comes off
// the free list, whose links live in a 64K-entry memory with a registered read port.
// A too-large, rejected or unknown command goes from dispatch to the result. Free
// pushes the unit back; a reallocate that does not fit in place runs the allocate
// steps, then frees the old unit. The next command is accepted once the result is
// placed in the output register; a result not yet taken holds the next one back.
module size_class_slab_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // req_bytes[31:0], in_page[34:32], in_offset[53:35]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata    // status[1:0], out_page[4:2], out_offset[23:5],
                                   // granted_bytes[39:24], moved[40], copy_bytes[56:41]
);
    import scsa_pkg::*;

    ctl_cmd_t           cmd;
    dp_stat_t           stat;
    logic [1:0]         status;
    logic [SLOT_W-1:0]  out_page;
    logic [OFF_W-1:0]   out_offset;
    logic [BYTES_W-1:0] granted_bytes;
    logic               moved;
    logic [BYTES_W-1:0] copy_bytes;

    scsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    scsa_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_cmd        (s_tuser),
        .in_req        (s_tdata[31:0]),
        .in_page       (s_tdata[34:32]),
        .in_offset     (s_tdata[53:35]),
        .out_ready     (m_tready),
        .out_valid     (m_tvalid),
        .status        (status),
        .out_page      (out_page),
        .out_offset    (out_offset),
        .granted_bytes (granted_bytes),
        .moved         (moved),
        .copy_bytes    (copy_bytes)
    );

    assign m_tdata = {7'b0, copy_bytes, moved, granted_bytes, out_offset, out_page, status};

endmodule
